### rtl/tvd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvd_pkg;

  localparam int VERTEX_BITS  = 64;
  localparam int VERTEX_DEPTH = 1024;
  localparam int TRIANGLE_MAX = 65536;

  // Field widths of the channels
  localparam int KEY_IN_W  = 64;
  localparam int LIMIT_W   = 11;
  localparam int STATUS_W  = 2;
  localparam int TRI_NUM_W = 16;
  localparam int IDX_W     = 10;
  localparam int MASK_W    = 3;

  localparam int VADDR_W   = $clog2(VERTEX_DEPTH);
  localparam int VCNT_W    = $clog2(VERTEX_DEPTH + 1);
  localparam int TCNT_W    = $clog2(TRIANGLE_MAX + 1);
  localparam int CMP_W     = ((LIMIT_W > VCNT_W) ? LIMIT_W : VCNT_W) + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

endpackage
`default_nettype wire

### rtl/tvd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tvd_in_if import tvd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_IN_W-1:0] vertex_a;
  logic [KEY_IN_W-1:0] vertex_b;
  logic [KEY_IN_W-1:0] vertex_c;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  output ready);
endinterface

interface tvd_out_if import tvd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TRI_NUM_W-1:0] triangle_number;
  logic [IDX_W-1:0]     index_a;
  logic [IDX_W-1:0]     index_b;
  logic [IDX_W-1:0]     index_c;
  logic [MASK_W-1:0]    new_mask;

  modport source (output valid, output status, output triangle_number,
                  output index_a, output index_b, output index_c, output new_mask,
                  input ready);
  modport sink   (input valid, input status, input triangle_number,
                  input index_a, input index_b, input index_c, input new_mask,
                  output ready);
endinterface

interface tvd_cfg_if import tvd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] vertex_limit;

  modport source (output valid, output vertex_limit, input ready);
  modport sink   (input valid, input vertex_limit, output ready);
endinterface
`default_nettype wire

### rtl/triangle_vertex_deduplicator_unit.sv
// From accepted word to result word the block scans the vertex store linearly through its
// single read port, one entry per cycle, all three keys at once; a refused triangle skips
// the appends. Only one triangle is in flight: the next word is taken the cycle after the
// result is loaded into the output register. Reset clears vertex and triangle counts and
// sets vertex_limit to 1024.
`timescale 1ns / 1ps
`default_nettype none
module triangle_vertex_deduplicator_unit import tvd_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  tvd_in_if.sink       in_ch,
  tvd_out_if.source    out_ch,
  tvd_cfg_if.sink      cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_APPEND,
    S_FINISH
  } state_t;

  state_t                 state_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic [VCNT_W-1:0]      vcount_r;
  logic [TCNT_W-1:0]      tcount_r;

  logic [VERTEX_BITS-1:0] key_r   [3];
  logic [VADDR_W-1:0]     idx_r   [3];
  logic [2:0]             found_r;
  logic [MASK_W-1:0]      mask_r;
  logic                   full_r;
  logic [1:0]             app_k_r;

  logic [VCNT_W-1:0]      issue_r;
  logic                   rd_vld_r;
  logic [VADDR_W-1:0]     rd_idx_r;
  logic [VERTEX_BITS-1:0] rd_data_r;

  logic                   out_vld_r;
  status_t                out_status_r;
  logic [TRI_NUM_W-1:0]   out_tri_r;
  logic [IDX_W-1:0]       out_idx_r [3];
  logic [MASK_W-1:0]      out_mask_r;

  logic [VERTEX_BITS-1:0] mem [VERTEX_DEPTH];

  logic                   in_acc;
  logic                   mem_re;
  logic                   mem_we;
  logic [2:0]             hit;
  logic [1:0]             need;
  logic [CMP_W-1:0]       limit_eff;
  logic [CMP_W-1:0]       demand;
  logic                   out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_vld_r || out_ch.ready;

  assign mem_re = (state_r == S_SCAN) && (issue_r < vcount_r);
  assign mem_we = (state_r == S_APPEND) && !found_r[app_k_r];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hit[k] = rd_vld_r && !found_r[k] && (rd_data_r == key_r[k]);
    end
    need = 2'(3 - $countones(found_r));
    limit_eff = (CMP_W'(limit_r) > CMP_W'(VERTEX_DEPTH)) ? CMP_W'(VERTEX_DEPTH)
                                                          : CMP_W'(limit_r);
    demand = CMP_W'(vcount_r) + CMP_W'(need);
  end

  // Vertex store: one read port, one write port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[issue_r[VADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[vcount_r[VADDR_W-1:0]] <= key_r[app_k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      limit_r   <= LIMIT_RESET;
      vcount_r  <= '0;
      tcount_r  <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.vertex_limit;
      end
      if (out_vld_r && out_ch.ready && !((state_r == S_FINISH) && out_free)) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            key_r[0] <= in_ch.vertex_a[VERTEX_BITS-1:0];
            key_r[1] <= in_ch.vertex_b[VERTEX_BITS-1:0];
            key_r[2] <= in_ch.vertex_c[VERTEX_BITS-1:0];
            found_r  <= '0;
            mask_r   <= '0;
            full_r   <= 1'b0;
            issue_r  <= '0;
            rd_vld_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Keep the first match per corner
          for (int k = 0; k < 3; k++) begin
            if (hit[k]) begin
              found_r[k] <= 1'b1;
              idx_r[k]   <= rd_idx_r;
            end
          end
          rd_vld_r <= mem_re;
          rd_idx_r <= issue_r[VADDR_W-1:0];
          if (mem_re) begin
            issue_r <= issue_r + 1'b1;
          end else if (!rd_vld_r) begin
            state_r <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          app_k_r <= '0;
          if (demand > limit_eff) begin
            full_r  <= 1'b1;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_APPEND;
          end
        end

        S_APPEND: begin
          if (mem_we) begin
            idx_r[app_k_r]  <= vcount_r[VADDR_W-1:0];
            mask_r[app_k_r] <= 1'b1;
            vcount_r        <= vcount_r + 1'b1;
          end
          if (app_k_r == 2'd2) begin
            state_r <= S_FINISH;
          end else begin
            app_k_r <= app_k_r + 1'b1;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
            if (full_r) begin
              out_status_r <= ST_FULL;
              out_tri_r    <= '0;
              out_mask_r   <= '0;
              for (int k = 0; k < 3; k++) begin
                out_idx_r[k] <= '0;
              end
            end else begin
              out_mask_r <= mask_r;
              for (int k = 0; k < 3; k++) begin
                out_idx_r[k] <= IDX_W'(idx_r[k]);
              end
              if (tcount_r >= TCNT_W'(TRIANGLE_MAX)) begin
                out_status_r <= ST_EXHAUSTED;
                out_tri_r    <= '0;
              end else begin
                out_status_r <= ST_OK;
                out_tri_r    <= TRI_NUM_W'(tcount_r);
                tcount_r     <= tcount_r + 1'b1;
              end
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.triangle_number = out_tri_r;
  assign out_ch.index_a         = out_idx_r[0];
  assign out_ch.index_b         = out_idx_r[1];
  assign out_ch.index_c         = out_idx_r[2];
  assign out_ch.new_mask        = out_mask_r;

  a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= VCNT_W'(VERTEX_DEPTH))
    else $error("vertex count beyond store depth");

  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (VCNT_W'(rd_idx_r) < vcount_r))
    else $error("compare on a store entry never written");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (vcount_r < VCNT_W'(VERTEX_DEPTH)) && !full_r)
    else $error("append beyond store or on refused triangle");

  a_tcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcount_r <= TCNT_W'(TRIANGLE_MAX))
    else $error("triangle count beyond maximum");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) && full_r |-> (mask_r == '0))
    else $error("refused triangle marked corners as appended");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tvd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 2;
  // Slowest legal run: ~600 triangles at up to a full store scan each,
  // with stalls on both sides and one long hold; keep several times that.
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = VERTEX_DEPTH + 32;
  localparam int IDLE_PCT      = 33;
  localparam int MAX_PRINTS    = 30;
  localparam int NO_MATCH      = -1;

  localparam logic [KEY_IN_W-1:0] KEY_MASK =
    (VERTEX_BITS >= KEY_IN_W) ? '1 : ((KEY_IN_W'(1) << VERTEX_BITS) - KEY_IN_W'(1));

  typedef struct packed {
    status_t              status;
    logic [TRI_NUM_W-1:0] tri_num;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;
    logic [IDX_W-1:0]     idx_c;
    logic [MASK_W-1:0]    fresh;
  } tri_result_t;

  typedef struct packed {
    logic        pinned;
    tri_result_t res;
  } table_expect_t;

  typedef struct packed {
    logic                is_cfg;
    logic [LIMIT_W-1:0]  limit;
    logic [KEY_IN_W-1:0] ka, kb, kc;
    logic                pinned;
    tri_result_t         res;
  } plan_row_t;

  localparam logic [KEY_IN_W-1:0] K_ZERO = '0;
  localparam logic [KEY_IN_W-1:0] K_ONES = '1;
  localparam logic [KEY_IN_W-1:0] K_P    = 64'h0123_4567_89AB_CDEF;
  localparam logic [KEY_IN_W-1:0] K_Q    = 64'hFEDC_BA98_7654_3210;
  localparam logic [KEY_IN_W-1:0] K_R    = 64'h8000_0000_0000_0001;
  localparam logic [KEY_IN_W-1:0] K_S    = 64'h5555_5555_5555_5555;
  localparam logic [KEY_IN_W-1:0] K_T    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KEY_IN_W-1:0] K_U    = 64'h3333_3333_3333_3333;

  localparam tri_result_t NO_RESULT   = '0;
  localparam tri_result_t FULL_RESULT = '{ST_FULL, '0, '0, '0, '0, '0};

  localparam int PLAN_LEN = 15;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // empty store: equal new keys in one triangle get separate entries
    '{1'b0, '0, K_ZERO, K_ONES, K_ZERO, 1'b1, '{ST_OK, 16'd0, 10'd0, 10'd1, 10'd2, 3'd7}},
    // all found: lowest matching entry wins
    '{1'b0, '0, K_ZERO, K_ONES, K_ZERO, 1'b1, '{ST_OK, 16'd1, 10'd0, 10'd1, 10'd0, 3'd0}},
    '{1'b0, '0, K_P, K_P, K_P, 1'b1, '{ST_OK, 16'd2, 10'd3, 10'd4, 10'd5, 3'd7}},
    '{1'b0, '0, K_P, K_ZERO, K_Q, 1'b0, NO_RESULT},
    // limit under the vertex count
    '{1'b1, 11'd0, K_ZERO, K_ZERO, K_ZERO, 1'b0, NO_RESULT},
    '{1'b0, '0, K_ONES, K_P, K_ZERO, 1'b0, NO_RESULT},
    '{1'b0, '0, K_R, K_ZERO, K_ZERO, 1'b1, FULL_RESULT},
    // limit above capacity
    '{1'b1, 11'd2047, K_ZERO, K_ZERO, K_ZERO, 1'b0, NO_RESULT},
    '{1'b0, '0, K_R, K_Q, K_S, 1'b0, NO_RESULT},
    // nine stored, limit ten: two new refused, one new fits exactly
    '{1'b1, 11'd10, K_ZERO, K_ZERO, K_ZERO, 1'b0, NO_RESULT},
    '{1'b0, '0, K_T, K_R, K_U, 1'b1, FULL_RESULT},
    '{1'b0, '0, K_T, K_R, K_T, 1'b1, FULL_RESULT},
    '{1'b0, '0, K_T, K_R, K_Q, 1'b0, NO_RESULT},
    '{1'b0, '0, K_R, K_R, K_R, 1'b0, NO_RESULT},
    '{1'b1, 11'd12, K_ZERO, K_ZERO, K_ZERO, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;

  tvd_in_if  in_ch ();
  tvd_out_if out_ch ();
  tvd_cfg_if cfg_ch ();

  triangle_vertex_deduplicator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the block state
  logic [KEY_IN_W-1:0] key_store [VERTEX_DEPTH];
  int                  vert_cnt  = 0;
  int                  tri_cnt   = 0;
  logic [LIMIT_W-1:0]  limit_reg = LIMIT_RESET;

  tri_result_t   awaited_results [$];
  table_expect_t table_expect_q [$];
  int            mismatches = 0;
  int            results_seen = 0;
  bit            steady = 1'b0;
  bit            hold_armed = 1'b0;

  function automatic int effective_limit();
    return (limit_reg > VERTEX_DEPTH) ? VERTEX_DEPTH : int'(limit_reg);
  endfunction

  function automatic tri_result_t dedup_triangle(input logic [KEY_IN_W-1:0] ka, kb, kc);
    logic [KEY_IN_W-1:0] keys [3];
    int                  slot [3];
    int                  need;
    int                  i;
    int                  k;
    tri_result_t         res;
    keys[0] = ka & KEY_MASK;
    keys[1] = kb & KEY_MASK;
    keys[2] = kc & KEY_MASK;
    need = 0;
    res = '0;
    // search all three before any append
    for (k = 0; k < 3; k++) begin
      slot[k] = NO_MATCH;
      for (i = 0; i < vert_cnt && slot[k] == NO_MATCH; i++)
        if (key_store[i] == keys[k]) slot[k] = i;
      if (slot[k] == NO_MATCH) need++;
    end
    if (vert_cnt + need > effective_limit()) begin
      res.status = ST_FULL;
      return res;
    end
    for (k = 0; k < 3; k++) begin
      if (slot[k] == NO_MATCH) begin
        if (vert_cnt < VERTEX_DEPTH) key_store[vert_cnt] = keys[k];
        slot[k] = vert_cnt;
        vert_cnt++;
        res.fresh[k] = 1'b1;
      end
    end
    if (tri_cnt >= TRIANGLE_MAX) begin
      res.status = ST_EXHAUSTED;
    end else begin
      res.status = ST_OK;
      res.tri_num = tri_cnt[TRI_NUM_W-1:0];
      tri_cnt++;
    end
    res.idx_a = slot[0][IDX_W-1:0];
    res.idx_b = slot[1][IDX_W-1:0];
    res.idx_c = slot[2][IDX_W-1:0];
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t, result %0d: %s", $time, results_seen, msg);
  endtask

  // Predict on every accepted word, check every delivered word
  always @(posedge clk) begin : scoreboard
    tri_result_t   predicted;
    tri_result_t   want;
    tri_result_t   got;
    table_expect_t note;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) limit_reg = cfg_ch.vertex_limit;
      if (in_ch.valid && in_ch.ready) begin
        predicted = dedup_triangle(in_ch.vertex_a, in_ch.vertex_b, in_ch.vertex_c);
        note = table_expect_q.pop_front();
        awaited_results.push_back(note.pinned ? note.res : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status  = status_t'(out_ch.status);
        got.tri_num = out_ch.triangle_number;
        got.idx_a   = out_ch.index_a;
        got.idx_b   = out_ch.index_b;
        got.idx_c   = out_ch.index_c;
        got.fresh   = out_ch.new_mask;
        if (awaited_results.size() == 0) begin
          log_mismatch("result word with nothing pending");
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.tri_num !== want.tri_num)
            log_mismatch($sformatf("triangle_number %0d, want %0d", got.tri_num, want.tri_num));
          if (got.idx_a !== want.idx_a)
            log_mismatch($sformatf("index_a %0d, want %0d", got.idx_a, want.idx_a));
          if (got.idx_b !== want.idx_b)
            log_mismatch($sformatf("index_b %0d, want %0d", got.idx_b, want.idx_b));
          if (got.idx_c !== want.idx_c)
            log_mismatch($sformatf("index_c %0d, want %0d", got.idx_c, want.idx_c));
          if (got.fresh !== want.fresh)
            log_mismatch($sformatf("new_mask %0b, want %0b", got.fresh, want.fresh));
        end
        results_seen++;
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_armed && !hold_done && out_ch.valid) begin
        // hold off long enough for the block to back up into its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, awaited_results.size());
    $display("FAIL");
    $finish;
  end

  task automatic offer_triangle(input logic [KEY_IN_W-1:0] ka, kb, kc,
                                input logic pinned, input tri_result_t res);
    table_expect_t note;
    note.pinned = pinned;
    note.res = res;
    table_expect_q.push_back(note);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid    <= 1'b1;
    in_ch.vertex_a <= ka;
    in_ch.vertex_b <= kb;
    in_ch.vertex_c <= kc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every result word is back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.vertex_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [KEY_IN_W-1:0] draw_key(input int reuse_pct);
    if (vert_cnt > 0 && $urandom_range(99) < reuse_pct)
      return key_store[$urandom_range(vert_cnt - 1)];
    case ($urandom_range(19))
      0:       return K_ZERO;
      1:       return K_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_triangles(input int count);
    int                  reuse;
    logic [KEY_IN_W-1:0] ka, kb, kc;
    repeat (count) begin
      // mostly fresh keys while there is room, mostly stored keys once full
      reuse = (vert_cnt + 3 <= effective_limit()) ? 15 : 85;
      ka = draw_key(reuse);
      kb = draw_key(reuse);
      kc = draw_key(reuse);
      case ($urandom_range(9))
        0:       kb = ka;
        1:       kc = ka;
        2:       kc = kb;
        default: ;
      endcase
      offer_triangle(ka, kb, kc, 1'b0, NO_RESULT);
    end
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.vertex_a      <= '0;
    in_ch.vertex_b      <= '0;
    in_ch.vertex_c      <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.vertex_limit <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].is_cfg) begin
        wait_idle();
        write_limit(PLAN[r].limit);
      end else begin
        offer_triangle(PLAN[r].ka, PLAN[r].kb, PLAN[r].kc, PLAN[r].pinned, PLAN[r].res);
      end
    end

    // small store: mix of hits, appends and refusals
    random_triangles(40);
    wait_idle();
    random_triangles(40);
    wait_idle();

    // grow the store to capacity through several limits
    write_limit(11'd400);
    hold_armed = 1'b1;
    random_triangles(160);
    wait_idle();
    write_limit(11'd0);
    random_triangles(12);
    wait_idle();
    write_limit(11'd1025);
    // no idling on either side for this stretch
    steady = 1'b1;
    random_triangles(200);
    wait_idle();
    steady = 1'b0;
    write_limit(11'd2047);
    random_triangles(140);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
